// ===== src/rssb_pkg.sv =====
`timescale 1ns / 1ps

package rssb_pkg;

  // Depth of the holding queue and the widths that follow from it.
  localparam int HOLD_DEPTH = 32;
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
  localparam int IDX_W      = $clog2(HOLD_DEPTH);

  localparam logic [31:0] GAP_RESET = 32'd4500;

  // One held packet descriptor.
  typedef struct packed {
    logic [31:0] source_id;
    logic [31:0] media_time;
    logic [15:0] tag;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_load;
    logic direct_out;
    logic append;
    logic adopt;
    logic rd_issue;
    logic send;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dummy;
    logic match;
    logic full;
    logic stale;
    logic gap_hold;
    logic out_free;
    logic last_entry;
  } sts_t;

endpackage

// ===== src/rssb_if.sv =====
`timescale 1ns / 1ps

// Incoming packet descriptors.
interface rssb_pkt_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_id;
  logic [31:0] media_time;
  logic [15:0] packet_tag;
  logic        is_dummy;

  modport source (output valid, source_id, media_time, packet_tag, is_dummy, input ready);
  modport sink (input valid, source_id, media_time, packet_tag, is_dummy, output ready);
endinterface

// Released packet descriptors.
interface rssb_rel_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_source_id;
  logic [31:0] out_media_time;
  logic [15:0] out_tag;
  logic        last;

  modport source (output valid, out_source_id, out_media_time, out_tag, last, input ready);
  modport sink (input valid, out_source_id, out_media_time, out_tag, last, output ready);
endinterface

// ===== src/rssb_ctrl.sv =====
`timescale 1ns / 1ps

module rssb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rssb_pkg::sts_t sts,
  output rssb_pkg::cmd_t cmd
);
  import rssb_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    GAP,
    READ,
    SEND
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid && in_ready) begin
          cmd.in_load = 1'b1;
          state_next  = CHECK;
        end
      end
      CHECK: begin
        if (sts.dummy) begin
          state_next = IDLE;
        end else if (sts.match) begin
          if (sts.out_free) begin
            cmd.direct_out = 1'b1;
            state_next     = IDLE;
          end
        end else if (sts.full || sts.stale) begin
          state_next = IDLE;
        end else begin
          cmd.append = 1'b1;
          state_next = GAP;
        end
      end
      GAP: begin
        if (sts.gap_hold) begin
          state_next = IDLE;
        end else begin
          cmd.adopt  = 1'b1;
          state_next = READ;
        end
      end
      READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = SEND;
      end
      SEND: begin
        if (sts.out_free) begin
          cmd.send   = 1'b1;
          state_next = sts.last_entry ? IDLE : READ;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == IDLE);
    end
  end

endmodule

// ===== src/rssb_dp.sv =====
`timescale 1ns / 1ps

module rssb_dp (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata,
  rssb_pkt_if.sink       packets,
  rssb_rel_if.source     released,
  input  rssb_pkg::cmd_t cmd,
  output rssb_pkg::sts_t sts
);
  import rssb_pkg::*;

  logic [31:0] max_gap;
  logic [31:0] active_source;
  logic [31:0] last_time;
  logic        time_known;
  logic [CNT_W-1:0] held_count;
  logic [IDX_W-1:0] flush_idx;

  // Captured input item.
  entry_t in_entry;
  logic   in_dummy;

  // Front of the queue kept apart so the gap check needs no memory read.
  logic [31:0] front_source;
  logic [31:0] front_time;

  entry_t mem [HOLD_DEPTH];
  entry_t rd_entry;

  entry_t out_entry;
  logic   out_last;
  logic   out_valid;

  logic [31:0] delta;
  logic [31:0] gap;

  assign delta = in_entry.media_time - last_time;
  assign gap   = front_time - last_time;

  always_comb begin
    sts.dummy      = in_dummy;
    sts.match      = (in_entry.source_id == active_source);
    sts.full       = (held_count == CNT_W'(HOLD_DEPTH));
    sts.stale      = time_known && ((delta == 32'd0) || delta[31]);
    sts.gap_hold   = time_known && (gap > max_gap);
    sts.out_free   = !out_valid || released.ready;
    sts.last_entry = ((CNT_W'(flush_idx) + CNT_W'(1)) == held_count);
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      in_entry.source_id  <= packets.source_id;
      in_entry.media_time <= packets.media_time;
      in_entry.tag        <= packets.packet_tag;
      in_dummy            <= packets.is_dummy;
    end
    if (cmd.append) begin
      mem[held_count[IDX_W-1:0]] <= in_entry;
      if (held_count == '0) begin
        front_source <= in_entry.source_id;
        front_time   <= in_entry.media_time;
      end
    end
    if (cmd.rd_issue) begin
      rd_entry <= mem[flush_idx];
    end
    if (cmd.direct_out) begin
      out_entry <= in_entry;
      out_last  <= 1'b1;
    end else if (cmd.send) begin
      out_entry <= rd_entry;
      out_last  <= sts.last_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gap       <= GAP_RESET;
      active_source <= '0;
      last_time     <= '0;
      time_known    <= 1'b0;
      held_count    <= '0;
      flush_idx     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_gap <= cfg_wdata;
      end
      if (cmd.append) begin
        held_count <= held_count + CNT_W'(1);
      end
      if (cmd.adopt) begin
        active_source <= front_source;
        flush_idx     <= '0;
      end
      if (cmd.direct_out) begin
        last_time  <= in_entry.media_time;
        time_known <= 1'b1;
      end else if (cmd.send) begin
        last_time  <= rd_entry.media_time;
        time_known <= 1'b1;
        flush_idx  <= flush_idx + IDX_W'(1);
        if (sts.last_entry) begin
          held_count <= '0;
        end
      end
      if (cmd.direct_out || cmd.send) begin
        out_valid <= 1'b1;
      end else if (released.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign released.valid          = out_valid;
  assign released.out_source_id  = out_entry.source_id;
  assign released.out_media_time = out_entry.media_time;
  assign released.out_tag        = out_entry.tag;
  assign released.last           = out_last;

endmodule

// ===== src/rtp_source_switch_buffer.sv =====
`timescale 1ns / 1ps

// Channel    Role     Item
// packets    sink     source_id, media_time, packet_tag, is_dummy
// released   source   out_source_id, out_media_time, out_tag, last
// cfg        write    max_gap (cfg_we, cfg_wdata)
//
// An item is taken in one cycle and checked in the next. A dropped item then frees the
// block, and a directly passed item does so once the output register is free. An item that
// joins the holding queue goes on to the gap check; a flush then reads each held item into a
// register through the single registered read port of the queue memory before it is sent.
// Reset is synchronous; it restores the gap limit and clears the source state, the queue
// count and the output register, but not the queue memory. A stalled output holds the
// controller in place, and no new item is taken until the current one is finished.
module rtp_source_switch_buffer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  rssb_pkt_if.sink    packets,
  rssb_rel_if.source  released
);
  import rssb_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // Only one item is in the block at a time; ready is high only while idle.
  assign packets.ready = in_ready;

  // The controller sequences checks, queue appends and the flush walk.
  rssb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (packets.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the source state, the queue memory and the output register.
  rssb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .packets   (packets),
    .released  (released),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef NO_ASSERTIONS
  // The queue is never appended to when it is already full.
  assert property (@(posedge clk) disable iff (rst) cmd.append |-> !sts.full)
    else $error("append to a full holding queue");

  // A result is only loaded when the output register can take it.
  assert property (@(posedge clk) disable iff (rst)
      (cmd.send || cmd.direct_out) |-> sts.out_free)
    else $error("output register overwritten");

  // After an item is taken, the next one waits at least until it is checked.
  assert property (@(posedge clk) disable iff (rst)
      (packets.valid && packets.ready) |=> !packets.ready)
    else $error("second item taken while one is in flight");
`endif

endmodule
